// ===== rtl/gbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, register codes and constants for the gyro bias calibrator.
// ----------------------------------------------------------------------------
package gbc_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // raw count register width and its largest value
    localparam int         COUNT_W     = 12;
    localparam logic [11:0] COUNT_TOP  = 12'hFFF;

    // default sample cap
    localparam int MAX_SAMPLES_DEF = 4095;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_TEMP  = 3'd0,
        REG_TEMP_WINDOW  = 3'd1,
        REG_SETTLE_COUNT = 3'd2,
        REG_CALIB_COUNT  = 3'd3,
        REG_BIAS_LIMIT   = 3'd4,
        REG_Z_DEADBAND   = 3'd5,
        REG_SKIP_WARMUP  = 3'd6
    } t_reg_idx;

    // processing phases
    typedef enum logic [1:0] {
        PH_WARM  = 2'd0,
        PH_CALIB = 2'd1,
        PH_RUN   = 2'd2
    } t_phase;

    // register reset values
    localparam logic signed [15:0] RST_TARGET_TEMP  = 16'sd10240;
    localparam logic [14:0]        RST_TEMP_WINDOW  = 15'd128;
    localparam logic [11:0]        RST_SETTLE_COUNT = 12'd100;
    localparam logic [11:0]        RST_CALIB_COUNT  = 12'd1500;
    localparam logic [30:0]        RST_BIAS_LIMIT   = 31'd655;
    localparam logic [30:0]        RST_Z_DEADBAND   = 31'd6554;
    localparam logic               RST_SKIP_WARMUP  = 1'b1;

    // fallback biases, Q16.16
    localparam logic signed [31:0] STD_BIAS_X = 32'sd224;
    localparam logic signed [31:0] STD_BIAS_Y = -32'sd136;
    localparam logic signed [31:0] STD_BIAS_Z = -32'sd369;

    // saturation limits
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // configuration register bank
    typedef struct packed {
        logic signed [15:0] target_temp;
        logic [14:0]        temp_window;
        logic [11:0]        settle_count;
        logic [11:0]        calib_count;
        logic [30:0]        bias_limit;
        logic [30:0]        z_deadband;
        logic               skip_warmup;
    } t_cfg;

    // restart request raised by a skip_warmup write
    typedef struct packed {
        logic req;
        logic skip;
    } t_restart;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       emit;
        logic       accum;
        logic       clear_sums;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic       bias_load;
        logic [1:0] axis;
        t_phase     phase;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_band;
        logic out_free;
    } t_stat;

    // effective sample count: capped, zero acts as one
    function automatic logic [11:0] eff_count(input logic [11:0] c, input logic [11:0] cap);
        logic [11:0] v;
        v = (c > cap) ? cap : c;
        if (v == 12'd0) begin
            v = 12'd1;
        end
        return v;
    endfunction

endpackage

// ===== rtl/gbc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_cfg
// Configuration register bank; flags a restart on a skip_warmup write.
// ----------------------------------------------------------------------------
module gbc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output gbc_pkg::t_cfg                    o_cfg,
    output gbc_pkg::t_restart                o_restart
);

    gbc_pkg::t_cfg r_cfg;
    logic          wr;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid;
    assign o_cfg       = r_cfg;

    // restart request for the controller
    assign o_restart.req  = wr && (gbc_pkg::t_reg_idx'(i_cfg_index) == gbc_pkg::REG_SKIP_WARMUP);
    assign o_restart.skip = i_cfg_data[0];

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_temp  <= gbc_pkg::RST_TARGET_TEMP;
            r_cfg.temp_window  <= gbc_pkg::RST_TEMP_WINDOW;
            r_cfg.settle_count <= gbc_pkg::RST_SETTLE_COUNT;
            r_cfg.calib_count  <= gbc_pkg::RST_CALIB_COUNT;
            r_cfg.bias_limit   <= gbc_pkg::RST_BIAS_LIMIT;
            r_cfg.z_deadband   <= gbc_pkg::RST_Z_DEADBAND;
            r_cfg.skip_warmup  <= gbc_pkg::RST_SKIP_WARMUP;
        end else if (wr) begin
            case (gbc_pkg::t_reg_idx'(i_cfg_index))
                gbc_pkg::REG_TARGET_TEMP:  r_cfg.target_temp  <= i_cfg_data[15:0];
                gbc_pkg::REG_TEMP_WINDOW:  r_cfg.temp_window  <= i_cfg_data[14:0];
                gbc_pkg::REG_SETTLE_COUNT: r_cfg.settle_count <= i_cfg_data[11:0];
                gbc_pkg::REG_CALIB_COUNT:  r_cfg.calib_count  <= i_cfg_data[11:0];
                gbc_pkg::REG_BIAS_LIMIT:   r_cfg.bias_limit   <= i_cfg_data[30:0];
                gbc_pkg::REG_Z_DEADBAND:   r_cfg.z_deadband   <= i_cfg_data[30:0];
                gbc_pkg::REG_SKIP_WARMUP:  r_cfg.skip_warmup  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/gbc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_ctrl
// Phase sequencer: sample counting, division sequencing and handshake control.
// ----------------------------------------------------------------------------
module gbc_ctrl #(
    parameter int MAX_SAMPLES = gbc_pkg::MAX_SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gbc_pkg::t_cfg     i_cfg,
    input  gbc_pkg::t_restart i_restart,
    input  gbc_pkg::t_stat    i_stat,
    output gbc_pkg::t_cmd     o_cmd
);

    localparam int EFF_MAX = (MAX_SAMPLES < 4095) ? MAX_SAMPLES : 4095;
    localparam int CNT_W   = $clog2(EFF_MAX + 1);
    localparam int SUM_W   = 32 + CNT_W;
    localparam int STEP_W  = $clog2(SUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_STORE,
        S_BIAS
    } t_state;

    t_state          r_state, n_state;
    gbc_pkg::t_phase r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        r_axis, n_axis;
    logic [STEP_W-1:0] r_step, n_step;

    logic [11:0]      settle_full, calib_full;
    logic [CNT_W-1:0] settle_eff, calib_eff, cnt_inc;
    logic             emit;

    // effective counts
    assign settle_full = gbc_pkg::eff_count(i_cfg.settle_count, 12'(EFF_MAX));
    assign calib_full  = gbc_pkg::eff_count(i_cfg.calib_count, 12'(EFF_MAX));
    assign settle_eff  = settle_full[CNT_W-1:0];
    assign calib_eff   = calib_full[CNT_W-1:0];
    assign cnt_inc     = r_cnt + 1'b1;

    // commands decoded from state
    assign o_in_ready       = (r_state == S_IDLE);
    assign emit             = (r_state == S_EXEC) && i_stat.out_free;
    assign o_cmd.load_in    = o_in_ready && i_in_valid;
    assign o_cmd.emit       = emit;
    assign o_cmd.accum      = emit && (r_phase == gbc_pkg::PH_CALIB);
    assign o_cmd.clear_sums = (r_state == S_BIAS) || i_restart.req;
    assign o_cmd.div_load   = (r_state == S_DIV_LOAD);
    assign o_cmd.div_step   = (r_state == S_DIV_RUN);
    assign o_cmd.div_store  = (r_state == S_DIV_STORE);
    assign o_cmd.bias_load  = (r_state == S_BIAS);
    assign o_cmd.axis       = r_axis;
    assign o_cmd.phase      = r_phase;

    // next-state logic
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                    case (r_phase)
                        gbc_pkg::PH_WARM: begin
                            if (i_stat.in_band) begin
                                if (cnt_inc >= settle_eff) begin
                                    n_phase = gbc_pkg::PH_CALIB;
                                    n_cnt   = '0;
                                end else begin
                                    n_cnt = cnt_inc;
                                end
                            end
                        end
                        gbc_pkg::PH_CALIB: begin
                            if (cnt_inc >= calib_eff) begin
                                n_cnt   = '0;
                                n_axis  = 2'd0;
                                n_state = S_DIV_LOAD;
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV_LOAD: begin
                n_step  = STEP_W'(SUM_W - 1);
                n_state = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (r_step == '0) begin
                    n_state = S_DIV_STORE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_DIV_STORE: begin
                if (r_axis == 2'd2) begin
                    n_state = S_BIAS;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_DIV_LOAD;
                end
            end
            S_BIAS: begin
                n_phase = gbc_pkg::PH_RUN;
                n_cnt   = '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // restart from a skip_warmup write
        if (i_restart.req) begin
            n_phase = i_restart.skip ? gbc_pkg::PH_CALIB : gbc_pkg::PH_WARM;
            n_cnt   = '0;
        end
    end

    // state and registered control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= gbc_pkg::RST_SKIP_WARMUP ? gbc_pkg::PH_CALIB : gbc_pkg::PH_WARM;
            r_cnt   <= '0;
            r_axis  <= 2'd0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            r_step  <= n_step;
        end
    end

endmodule

// ===== rtl/gbc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_dp
// Datapath: sample capture, axis sums, shared serial divider, bias correction
// and the output register.
// ----------------------------------------------------------------------------
module gbc_dp #(
    parameter int MAX_SAMPLES = gbc_pkg::MAX_SAMPLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbc_pkg::t_cfg       i_cfg,
    input  gbc_pkg::t_cmd       i_cmd,
    output gbc_pkg::t_stat      o_stat,
    input  logic signed [15:0]  i_temperature,
    input  logic signed [31:0]  i_rate_x,
    input  logic signed [31:0]  i_rate_y,
    input  logic signed [31:0]  i_rate_z,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_fixed_x,
    output logic signed [31:0]  o_fixed_y,
    output logic signed [31:0]  o_fixed_z,
    output logic                o_rates_valid,
    output logic [1:0]          o_phase
);

    localparam int EFF_MAX = (MAX_SAMPLES < 4095) ? MAX_SAMPLES : 4095;
    localparam int CNT_W   = $clog2(EFF_MAX + 1);
    localparam int SUM_W   = 32 + CNT_W;

    // captured sample
    logic signed [15:0] r_temp;
    logic signed [31:0] r_rate [3];

    // calibration state
    logic signed [SUM_W-1:0] r_sum  [3];
    logic signed [31:0]      r_mean [3];
    logic signed [31:0]      r_bias [3];
    logic                    r_bad;

    // divider registers
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic             r_neg;

    // output register
    logic              r_out_valid;
    logic signed [31:0] r_fix [3];
    logic              r_rv;
    logic [1:0]        r_ph;

    logic [11:0]      calib_full;
    logic [CNT_W-1:0] divisor;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   trial_diff;
    logic             trial_ge;
    logic [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0] mean_wide;

    logic signed [16:0] temp_diff;
    logic [16:0]        temp_mag;

    logic signed [32:0] diff [3];
    logic [32:0]        z_mag;
    logic               z_dead;
    logic [31:0]        corr [3];

    // temperature band test
    assign temp_diff      = {r_temp[15], r_temp} - {i_cfg.target_temp[15], i_cfg.target_temp};
    assign temp_mag       = temp_diff[16] ? 17'(-temp_diff) : 17'(temp_diff);
    assign o_stat.in_band = temp_mag < {2'b00, i_cfg.temp_window};
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // divider step: restoring, one quotient bit per cycle
    assign calib_full = gbc_pkg::eff_count(i_cfg.calib_count, 12'(EFF_MAX));
    assign divisor    = calib_full[CNT_W-1:0];
    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_ge   = trial >= {1'b0, divisor};
    assign trial_diff = trial - {1'b0, divisor};
    assign sum_sel    = r_sum[i_cmd.axis];
    assign mean_wide  = r_neg ? (~r_quo + 1'b1) : r_quo;

    // run phase correction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {r_rate[i][31], r_rate[i]} - {r_bias[i][31], r_bias[i]};
        end
        z_mag  = diff[2][32] ? 33'(-diff[2]) : 33'(diff[2]);
        z_dead = z_mag < {2'b00, i_cfg.z_deadband};
        for (int i = 0; i < 3; i++) begin
            if (diff[i][32] != diff[i][31]) begin
                corr[i] = diff[i][32] ? gbc_pkg::SAT_NEG : gbc_pkg::SAT_POS;
            end else begin
                corr[i] = diff[i][31:0];
            end
        end
        if (z_dead) begin
            corr[2] = '0;
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_temp    <= i_temperature;
            r_rate[0] <= i_rate_x;
            r_rate[1] <= i_rate_y;
            r_rate[2] <= i_rate_z;
        end
    end

    // axis sums and biases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
            end
            r_bad <= 1'b0;
        end else begin
            if (i_cmd.clear_sums) begin
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= '0;
                end
            end else if (i_cmd.accum) begin
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= r_sum[i] + {{(SUM_W-32){r_rate[i][31]}}, r_rate[i]};
                end
            end
            if (i_cmd.div_load && (i_cmd.axis == 2'd0)) begin
                r_bad <= 1'b0;
            end else if (i_cmd.div_store) begin
                r_bad <= r_bad || (r_quo > {{(SUM_W-31){1'b0}}, i_cfg.bias_limit});
            end
            if (i_cmd.bias_load) begin
                if (r_bad) begin
                    r_bias[0] <= gbc_pkg::STD_BIAS_X;
                    r_bias[1] <= gbc_pkg::STD_BIAS_Y;
                    r_bias[2] <= gbc_pkg::STD_BIAS_Z;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_bias[i] <= r_mean[i];
                    end
                end
            end
        end
    end

    // shared divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg <= sum_sel[SUM_W-1];
            r_quo <= sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], trial_ge};
        end
        if (i_cmd.div_store) begin
            r_mean[i_cmd.axis] <= mean_wide[31:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ph <= i_cmd.phase;
            if (i_cmd.phase == gbc_pkg::PH_RUN) begin
                for (int i = 0; i < 3; i++) begin
                    r_fix[i] <= corr[i];
                end
                r_rv <= 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_fix[i] <= '0;
                end
                r_rv <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fixed_x     = r_fix[0];
    assign o_fixed_y     = r_fix[1];
    assign o_fixed_z     = r_fix[2];
    assign o_rates_valid = r_rv;
    assign o_phase       = r_ph;

endmodule

// ===== rtl/gyro_bias_calibrate_correct_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_correct_top
// Gyro static bias calibration and correction: warm-up, averaging, run.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | temperature, rate_x/y/z
//  out     | source    | o_out_valid / i_out_ready  | fixed_x/y/z, rates_valid, phase
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
//  A sample is captured, then an update step updates the phase state and
//  loads the output register; the next sample is taken only after that step.
//  The sample that ends calibration then runs the shared one-bit-per-cycle
//  divider (SUM_W = 32 + count width bits) per axis, then loads the biases.
//  A full output register holds the block in its update cycle until drained.
//  Synchronous active-low reset; no clearing pass. Configuration is always ready.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_correct_top #(
    parameter int MAX_SAMPLES = gbc_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [15:0]              i_temperature,
    input  logic signed [31:0]              i_rate_x,
    input  logic signed [31:0]              i_rate_y,
    input  logic signed [31:0]              i_rate_z,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [31:0]              o_fixed_x,
    output logic signed [31:0]              o_fixed_y,
    output logic signed [31:0]              o_fixed_z,
    output logic                            o_rates_valid,
    output logic [1:0]                      o_phase,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    gbc_pkg::t_cfg     cfg;
    gbc_pkg::t_restart restart;
    gbc_pkg::t_cmd     cmd;
    gbc_pkg::t_stat    stat;

    // configuration registers
    gbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_restart   (restart)
    );

    // phase sequencer
    gbc_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cfg      (cfg),
        .i_restart  (restart),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    gbc_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_temperature (i_temperature),
        .i_rate_x      (i_rate_x),
        .i_rate_y      (i_rate_y),
        .i_rate_z      (i_rate_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fixed_x     (o_fixed_x),
        .o_fixed_y     (o_fixed_y),
        .o_fixed_z     (o_fixed_z),
        .o_rates_valid (o_rates_valid),
        .o_phase       (o_phase)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gyro bias calibrator. A bit-exact predictor
// tracks phase, sample counter, axis sums and biases per accepted sample.
// Directed cases cover the temperature band edges, fallback biases,
// truncating averages, deadband edges and saturation. Randomized rounds then
// reprogram the registers and walk warm-up, calibration and run phases with
// random gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import gbc_pkg::*;

    localparam int                     CYCLE_LIMIT    = 400000;
    localparam int                     RANDOM_SAMPLES = 1600;
    // longest sample: capture, update, bias division
    localparam int                     SETTLE_WAIT    = 160;
    localparam int                     MAX_REPORTS    = 20;
    localparam logic [CFG_IDX_W-1:0]   REG_UNUSED     = 3'd7;
    localparam logic signed [31:0]     RATE_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0]     RATE_MAX       = 32'sh7FFF_FFFF;

    // one corrected-rate transaction
    typedef struct packed {
        logic signed [31:0] fixed_x;
        logic signed [31:0] fixed_y;
        logic signed [31:0] fixed_z;
        logic               rates_valid;
        logic [1:0]         phase;
    } t_corrected;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic signed [15:0]     i_temperature;
    logic signed [31:0]     i_rate_x;
    logic signed [31:0]     i_rate_y;
    logic signed [31:0]     i_rate_z;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [31:0]     o_fixed_x;
    logic signed [31:0]     o_fixed_y;
    logic signed [31:0]     o_fixed_z;
    logic                   o_rates_valid;
    logic [1:0]             o_phase;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // calibrator model state
    t_cfg                   model_cfg;
    t_phase                 model_phase;
    logic [11:0]            model_count;
    longint                 model_sum [3];
    logic signed [31:0]     model_bias [3];

    t_corrected             expected_rates [$];
    int                     error_count;
    int                     samples_sent;
    bit                     idle_on;
    int unsigned            cycle_count = 0;

    gyro_bias_calibrate_correct_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_temperature (i_temperature),
        .i_rate_x      (i_rate_x),
        .i_rate_y      (i_rate_y),
        .i_rate_z      (i_rate_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fixed_x     (o_fixed_x),
        .o_fixed_y     (o_fixed_y),
        .o_fixed_z     (o_fixed_z),
        .o_rates_valid (o_rates_valid),
        .o_phase       (o_phase),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] clip32(input longint v);
        if (v > longint'(RATE_MAX)) return RATE_MAX;
        if (v < longint'(RATE_MIN)) return RATE_MIN;
        return v[31:0];
    endfunction

    // sample count actually used: capped, zero counts as one
    function automatic longint active_count(input logic [11:0] c);
        if (c > MAX_SAMPLES_DEF) return longint'(MAX_SAMPLES_DEF);
        if (c == 12'd0) return 1;
        return longint'(c);
    endfunction

    function automatic void model_restart();
        model_phase = model_cfg.skip_warmup ? PH_CALIB : PH_WARM;
        model_count = '0;
        for (int a = 0; a < 3; a++) model_sum[a] = 0;
    endfunction

    function automatic void model_reset();
        model_cfg.target_temp  = RST_TARGET_TEMP;
        model_cfg.temp_window  = RST_TEMP_WINDOW;
        model_cfg.settle_count = RST_SETTLE_COUNT;
        model_cfg.calib_count  = RST_CALIB_COUNT;
        model_cfg.bias_limit   = RST_BIAS_LIMIT;
        model_cfg.z_deadband   = RST_Z_DEADBAND;
        model_cfg.skip_warmup  = RST_SKIP_WARMUP;
        for (int a = 0; a < 3; a++) model_bias[a] = '0;
        model_restart();
    endfunction

    // register write as seen by the model
    function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TARGET_TEMP:  model_cfg.target_temp  = data[15:0];
            REG_TEMP_WINDOW:  model_cfg.temp_window  = data[14:0];
            REG_SETTLE_COUNT: model_cfg.settle_count = data[11:0];
            REG_CALIB_COUNT:  model_cfg.calib_count  = data[11:0];
            REG_BIAS_LIMIT:   model_cfg.bias_limit   = data[30:0];
            REG_Z_DEADBAND:   model_cfg.z_deadband   = data[30:0];
            REG_SKIP_WARMUP: begin
                model_cfg.skip_warmup = data[0];
                model_restart();
            end
            default: ;
        endcase
    endfunction

    // expected corrected rates for one sample, advances the model state
    function automatic t_corrected predict_sample(input logic signed [15:0] temp,
                                                  input logic signed [31:0] rx,
                                                  input logic signed [31:0] ry,
                                                  input logic signed [31:0] rz);
        t_corrected res;
        longint     r [3];
        longint     d [3];
        longint     mean [3];
        longint     n;
        logic       bad;
        r[0] = rx;
        r[1] = ry;
        r[2] = rz;
        res = '0;
        res.phase = model_phase;
        case (model_phase)
            // warm-up: count in-band samples
            PH_WARM: begin
                if (magnitude(longint'(temp) - longint'($signed(model_cfg.target_temp)))
                        < longint'(model_cfg.temp_window)) begin
                    model_count = model_count + 12'd1;
                    if (longint'(model_count) >= active_count(model_cfg.settle_count)) begin
                        model_phase = PH_CALIB;
                        model_count = '0;
                    end
                end
            end
            // calibration: accumulate, then average
            PH_CALIB: begin
                n = active_count(model_cfg.calib_count);
                model_count = model_count + 12'd1;
                for (int a = 0; a < 3; a++) model_sum[a] += r[a];
                if (longint'(model_count) >= n) begin
                    bad = 1'b0;
                    for (int a = 0; a < 3; a++) begin
                        mean[a] = model_sum[a] / n;
                        if (magnitude(mean[a]) > longint'(model_cfg.bias_limit)) bad = 1'b1;
                    end
                    if (bad) begin
                        model_bias[0] = STD_BIAS_X;
                        model_bias[1] = STD_BIAS_Y;
                        model_bias[2] = STD_BIAS_Z;
                    end else begin
                        for (int a = 0; a < 3; a++) model_bias[a] = mean[a][31:0];
                    end
                    model_phase = PH_RUN;
                    model_count = '0;
                    for (int a = 0; a < 3; a++) model_sum[a] = 0;
                end
            end
            // run: subtract bias, z deadband, saturate
            default: begin
                for (int a = 0; a < 3; a++) d[a] = r[a] - longint'(model_bias[a]);
                if (magnitude(d[2]) < longint'(model_cfg.z_deadband)) d[2] = 0;
                res.fixed_x     = clip32(d[0]);
                res.fixed_y     = clip32(d[1]);
                res.fixed_z     = clip32(d[2]);
                res.rates_valid = 1'b1;
            end
        endcase
        return res;
    endfunction

    // one sample transaction, with a random lead-in gap
    task automatic send_sample(input logic signed [15:0] temp,
                               input logic signed [31:0] rx,
                               input logic signed [31:0] ry,
                               input logic signed [31:0] rz);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_temperature = temp;
        i_rate_x      = rx;
        i_rate_y      = ry;
        i_rate_z      = rz;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_rates.push_back(predict_sample(temp, rx, ry, rz));
        samples_sent++;
    endtask

    // stop sending and wait for every pending result
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_rates.size() != 0) @(posedge i_clk);
    endtask

    // one register write transaction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        model_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // result side: random stalls, compare against oldest expectation
    initial begin : result_check
        int         stall;
        t_corrected want;
        t_corrected got;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.fixed_x     = o_fixed_x;
            got.fixed_y     = o_fixed_y;
            got.fixed_z     = o_fixed_z;
            got.rates_valid = o_rates_valid;
            got.phase       = o_phase;
            if (expected_rates.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t unexpected result: expected none, actual x=%0d y=%0d z=%0d valid=%0b phase=%0d",
                             $time, got.fixed_x, got.fixed_y, got.fixed_z,
                             got.rates_valid, got.phase);
                end
            end else begin
                want = expected_rates.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t mismatch: expected x=%0d y=%0d z=%0d valid=%0b phase=%0d",
                                 $time, want.fixed_x, want.fixed_y, want.fixed_z,
                                 want.rates_valid, want.phase);
                        $display("%0t           actual   x=%0d y=%0d z=%0d valid=%0b phase=%0d",
                                 $time, got.fixed_x, got.fixed_y, got.fixed_z,
                                 got.rates_valid, got.phase);
                    end
                end
            end
        end
    end

    // reset values: calibrating, outputs held at zero, field extremes
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF, RATE_MAX, RATE_MIN, 32'sh0000_0000);
        send_sample(16'sh8000, RATE_MIN, RATE_MAX, 32'sh5555_5555);
        send_sample(16'sh0000, -32'sd1, 32'sd1, 32'shAAAA_AAAA);
        wait_drained();
    endtask

    // warm-up band is strict at both edges
    task automatic test_warmup_band();
        write_reg(REG_TARGET_TEMP, 32'd0);
        write_reg(REG_TEMP_WINDOW, 32'd4);
        write_reg(REG_SETTLE_COUNT, 32'd3);
        write_reg(REG_CALIB_COUNT, 32'd2);
        write_reg(REG_SKIP_WARMUP, 32'd0);
        send_sample(16'sd4, $urandom, $urandom, $urandom);
        send_sample(-16'sd4, $urandom, $urandom, $urandom);
        send_sample(16'sd3, $urandom, $urandom, $urandom);
        send_sample(16'sh7FFF, $urandom, $urandom, $urandom);
        send_sample(-16'sd3, $urandom, $urandom, $urandom);
        send_sample(16'sd0, $urandom, $urandom, $urandom);
        wait_drained();
    endtask

    // out-of-limit mean selects fallback biases; deadband edges and saturation
    task automatic test_fallback_saturation();
        send_sample(16'sd0, RATE_MAX, 32'sd0, 32'sd0);
        send_sample(16'sd0, RATE_MAX, 32'sd0, 32'sd0);
        send_sample(16'sd0, RATE_MIN, RATE_MAX, STD_BIAS_Z + 32'sd6553);
        send_sample(16'sd0, $urandom, $urandom, STD_BIAS_Z + 32'sd6554);
        send_sample(16'sd0, $urandom, $urandom, STD_BIAS_Z - 32'sd6553);
        send_sample(16'sd0, $urandom, $urandom, STD_BIAS_Z - 32'sd6554);
        wait_drained();
    endtask

    // truncating average, mean equal to the limit, widest deadband
    task automatic test_bias_average();
        write_reg(REG_BIAS_LIMIT, 32'h7FFF_FFFF);
        write_reg(REG_CALIB_COUNT, 32'd3);
        write_reg(REG_SKIP_WARMUP, 32'd1);
        send_sample(16'sd0, -32'sd4, 32'sd2, 32'sd5);
        send_sample(16'sd0, -32'sd2, 32'sd2, 32'sd0);
        send_sample(16'sd0, -32'sd1, 32'sd4, 32'sd0);
        send_sample(16'sd0, RATE_MAX, RATE_MIN, $urandom);
        wait_drained();
        write_reg(REG_BIAS_LIMIT, 32'd0);
        write_reg(REG_CALIB_COUNT, 32'd0);
        write_reg(REG_Z_DEADBAND, 32'h7FFF_FFFF);
        write_reg(REG_SKIP_WARMUP, 32'd1);
        send_sample(16'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_sample(16'sd0, $urandom, $urandom, RATE_MIN);
        send_sample(16'sd0, $urandom, $urandom, RATE_MAX);
        send_sample(16'sd0, $urandom, $urandom, 32'sd5);
        wait_drained();
    endtask

    // widest band at the temperature floor, largest counts
    task automatic test_count_ceiling();
        write_reg(REG_TARGET_TEMP, 32'h0000_8000);
        write_reg(REG_TEMP_WINDOW, 32'h0000_7FFF);
        write_reg(REG_SETTLE_COUNT, 32'd4095);
        write_reg(REG_SKIP_WARMUP, 32'd0);
        send_sample(16'sh8000, $urandom, $urandom, $urandom);
        send_sample(16'sh7FFF, $urandom, $urandom, $urandom);
        send_sample(-16'sd1, $urandom, $urandom, $urandom);
        wait_drained();
        write_reg(REG_CALIB_COUNT, 32'd4095);
        write_reg(REG_SKIP_WARMUP, 32'd1);
        send_sample(16'sd0, RATE_MIN, RATE_MIN, RATE_MIN);
        wait_drained();
    endtask

    // random operating points, each walked through warm-up, calibration, run
    task automatic test_random_rounds();
        int                 start_count;
        int                 w;
        int                 cut_at;
        int                 calib_sent;
        int                 run_len;
        bit                 wild;
        bit                 cut;
        logic [31:0]        val;
        longint             t;
        longint             center [3];
        logic signed [15:0] temp;
        logic signed [31:0] rr [3];
        start_count = samples_sent;
        while (samples_sent - start_count < RANDOM_SAMPLES) begin
            wait_drained();
            idle_on = ($urandom_range(0, 3) != 0);

            // new register settings, upper data bits are don't-care
            case ($urandom_range(0, 7))
                0:       val = 32'h0000_8000;
                1:       val = 32'h0000_7FFF;
                default: val = $urandom;
            endcase
            write_reg(REG_TARGET_TEMP, val);
            val = $urandom;
            case ($urandom_range(0, 7))
                0:       val[14:0] = 15'd0;
                1:       val[14:0] = 15'h7FFF;
                default: val[14:0] = 15'($urandom_range(1, 600));
            endcase
            write_reg(REG_TEMP_WINDOW, val);
            val = $urandom;
            val[11:0] = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(7, 40))
                                                    : 12'($urandom_range(0, 6));
            write_reg(REG_SETTLE_COUNT, val);
            val = $urandom;
            val[11:0] = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(7, 40))
                                                    : 12'($urandom_range(0, 6));
            write_reg(REG_CALIB_COUNT, val);
            val = $urandom;
            case ($urandom_range(0, 7))
                0:       val[30:0] = 31'd0;
                1:       val[30:0] = 31'h7FFF_FFFF;
                2:       ;
                default: val[30:0] = 31'($urandom_range(0, 4000));
            endcase
            write_reg(REG_BIAS_LIMIT, val);
            val = $urandom;
            case ($urandom_range(0, 7))
                0:       val[30:0] = 31'd0;
                1:       val[30:0] = 31'h7FFF_FFFF;
                2:       ;
                default: val[30:0] = 31'($urandom_range(0, 20000));
            endcase
            write_reg(REG_Z_DEADBAND, val);
            if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
            // an empty band can never finish warm-up
            if (model_cfg.temp_window == 15'd0 || $urandom_range(0, 3) != 0) begin
                val = $urandom;
                if (model_cfg.temp_window == 15'd0) val[0] = 1'b1;
                write_reg(REG_SKIP_WARMUP, val);
            end

            // warm-up: mostly in-band temperatures
            while (model_phase == PH_WARM) begin
                if ($urandom_range(0, 3) != 0) begin
                    w = model_cfg.temp_window;
                    t = longint'($signed(model_cfg.target_temp))
                        + longint'($urandom_range(0, 2 * w - 2)) - longint'(w - 1);
                    if (t > 32767) t = 32767;
                    if (t < -32768) t = -32768;
                    temp = t[15:0];
                end else begin
                    temp = 16'($urandom);
                end
                send_sample(temp, $urandom, $urandom, $urandom);
            end

            // calibration: rates around a center, or wild; sometimes cut short
            wild = ($urandom_range(0, 3) == 0);
            cut = ($urandom_range(0, 7) == 0);
            cut_at = $urandom_range(0, 3);
            calib_sent = 0;
            for (int a = 0; a < 3; a++) center[a] = longint'($urandom_range(0, 4000)) - 2000;
            while (model_phase == PH_CALIB && !(cut && calib_sent >= cut_at)) begin
                for (int a = 0; a < 3; a++) begin
                    rr[a] = wild ? 32'($urandom)
                                 : clip32(center[a] + longint'($urandom_range(0, 1000)) - 500);
                end
                send_sample(16'($urandom), rr[0], rr[1], rr[2]);
                calib_sent++;
            end

            // run: extremes, random, near bias and near the deadband edges
            if (model_phase == PH_RUN) begin
                run_len = $urandom_range(4, 24);
                repeat (run_len) begin
                    for (int a = 0; a < 3; a++) begin
                        case ($urandom_range(0, 5))
                            0: rr[a] = RATE_MIN;
                            1: rr[a] = RATE_MAX;
                            2: rr[a] = $urandom;
                            3: rr[a] = clip32(longint'(model_bias[a])
                                              + longint'(model_cfg.z_deadband)
                                              + longint'($urandom_range(0, 2)) - 1);
                            4: rr[a] = clip32(longint'(model_bias[a])
                                              - longint'(model_cfg.z_deadband)
                                              + longint'($urandom_range(0, 2)) - 1);
                            default: rr[a] = clip32(longint'(model_bias[a])
                                                    + longint'($urandom_range(0, 2000)) - 1000);
                        endcase
                    end
                    send_sample(16'($urandom), rr[0], rr[1], rr[2]);
                end
            end
        end
    endtask

    // test sequence
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_temperature = '0;
        i_rate_x      = '0;
        i_rate_y      = '0;
        i_rate_z      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        idle_on       = 1'b1;
        error_count   = 0;
        samples_sent  = 0;
        model_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_warmup_band();
        test_fallback_saturation();
        test_bias_average();
        test_count_ceiling();
        test_random_rounds();

        // drain, then allow for a late extra transaction
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (error_count == 0 && expected_rates.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== gyro_bias_calibrate_correct_top.f =====
rtl/gbc_pkg.sv
rtl/gbc_cfg.sv
rtl/gbc_ctrl.sv
rtl/gbc_dp.sv
rtl/gyro_bias_calibrate_correct_top.sv
verif/tb_top.sv
